// ===== rtl/heater_channel_controller_unit_defines.svh =====
// Assertion macros shared by the heater channel controller RTL.
// Each check is live in simulation and compiles away for synthesis.
`ifndef HEATER_CHANNEL_CONTROLLER_UNIT_DEFINES_SVH
`define HEATER_CHANNEL_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define HCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcc check failed");

// Consequent must hold in the cycle after the antecedent
`define HCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcc check failed");

`else

`define HCC_ASSERT_SAME(label, clk, rst, ante, cons)
`define HCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/hcc_pkg.sv =====
package hcc_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned DUTY_W   = 8;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned CSR_W    = 16;

   // Reciprocal multiply for error * 255 / FULL_SCALE: shift and coefficient width
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned RECIP_W     = 28;
   localparam int unsigned DUTY_GAIN   = 255;

   localparam logic [DUTY_W-1:0]  DUTY_FULL = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_PRESENCE = 2'd0,
      KIND_CONTROL  = 2'd1,
      KIND_SWITCH_ON  = 2'd2,
      KIND_SWITCH_OFF = 2'd3
   } kind_type;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_TARGET_LEVEL        = 3'd0;
   localparam logic [INDEX_W-1:0] REG_HYSTERESIS_MARGIN   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_OVERTEMP_LIMIT      = 3'd2;
   localparam logic [INDEX_W-1:0] REG_ABSENT_THRESHOLD    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_ABSENT_COUNT_LIMIT  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_CONNECT_COUNT_LIMIT = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] TARGET_LEVEL_RST        = 10'd0;
   localparam logic [SAMPLE_W-1:0] HYSTERESIS_MARGIN_RST   = 10'd5;
   localparam logic [SAMPLE_W-1:0] OVERTEMP_LIMIT_RST      = 10'd1000;
   localparam logic [SAMPLE_W-1:0] ABSENT_THRESHOLD_RST    = 10'd1000;
   localparam logic [COUNT_W-1:0]  ABSENT_COUNT_LIMIT_RST  = 16'd10;
   localparam logic [COUNT_W-1:0]  CONNECT_COUNT_LIMIT_RST = 16'd10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] target_level;
      logic [SAMPLE_W-1:0] hysteresis_margin;
      logic [SAMPLE_W-1:0] overtemp_limit;
      logic [SAMPLE_W-1:0] absent_threshold;
      logic [COUNT_W-1:0]  absent_count_limit;
      logic [COUNT_W-1:0]  connect_count_limit;
   } hcc_cfg_type;

   typedef struct packed {
      logic              heater_enable;
      logic [DUTY_W-1:0] duty;
      logic              alarm;
      logic              present;
      logic              armed;
   } hcc_result_type;

endpackage

// ===== rtl/hcc_csr.sv =====
module hcc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [hcc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [hcc_pkg::CSR_W-1:0]    csr_write_data,
   output hcc_pkg::hcc_cfg_type         cfg
);
   import hcc_pkg::*;

   hcc_cfg_type cfg_ff;
   hcc_cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_TARGET_LEVEL:        cfg_in.target_level        = csr_write_data[SAMPLE_W-1:0];
            REG_HYSTERESIS_MARGIN:   cfg_in.hysteresis_margin   = csr_write_data[SAMPLE_W-1:0];
            REG_OVERTEMP_LIMIT:      cfg_in.overtemp_limit      = csr_write_data[SAMPLE_W-1:0];
            REG_ABSENT_THRESHOLD:    cfg_in.absent_threshold    = csr_write_data[SAMPLE_W-1:0];
            REG_ABSENT_COUNT_LIMIT:  cfg_in.absent_count_limit  = csr_write_data[COUNT_W-1:0];
            REG_CONNECT_COUNT_LIMIT: cfg_in.connect_count_limit = csr_write_data[COUNT_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_level        <= TARGET_LEVEL_RST;
         cfg_ff.hysteresis_margin   <= HYSTERESIS_MARGIN_RST;
         cfg_ff.overtemp_limit      <= OVERTEMP_LIMIT_RST;
         cfg_ff.absent_threshold    <= ABSENT_THRESHOLD_RST;
         cfg_ff.absent_count_limit  <= ABSENT_COUNT_LIMIT_RST;
         cfg_ff.connect_count_limit <= CONNECT_COUNT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/hcc_core.sv =====
module hcc_core #(
   parameter int unsigned FULL_SCALE = 400
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  hcc_pkg::kind_type             kind,
   input  logic [hcc_pkg::SAMPLE_W-1:0]  sample,
   input  hcc_pkg::hcc_cfg_type          cfg,
   output hcc_pkg::hcc_result_type       result
);
   import hcc_pkg::*;

   localparam int unsigned PROD_W = SAMPLE_W + RECIP_W;
   // ceil(255 * 2^20 / FULL_SCALE): exact quotient for every error below FULL_SCALE
   localparam longint unsigned RECIP_FULL =
      ((longint'(DUTY_GAIN) << RECIP_SHIFT) + longint'(FULL_SCALE) - 64'd1)
      / longint'(FULL_SCALE);
   localparam logic [RECIP_W-1:0]  DUTY_RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam logic [SAMPLE_W:0]   SCALE_CMP  = (SAMPLE_W+1)'(FULL_SCALE);

   logic                armed_ff, armed_in;
   logic                present_ff, present_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic                drive_ff, drive_in;
   logic                alarm;

   logic [SAMPLE_W:0]   err_wide;
   logic [SAMPLE_W-1:0] err_val;
   logic [PROD_W-1:0]   product;
   logic [DUTY_W-1:0]   duty_calc;
   logic [COUNT_W-1:0]  count_bump;
   logic [COUNT_W-1:0]  count_step;
   logic [COUNT_W-1:0]  count_limit;
   logic                beyond;

   // Proportional duty: zero the error when negative or below the margin, scale by reciprocal
   assign err_wide  = {1'b0, cfg.target_level} - {1'b0, sample};
   assign err_val   = (!err_wide[SAMPLE_W] && (err_wide[SAMPLE_W-1:0] >= cfg.hysteresis_margin))
                      ? err_wide[SAMPLE_W-1:0] : '0;
   assign product   = PROD_W'(err_val) * PROD_W'(DUTY_RECIP);
   assign duty_calc = ({1'b0, err_val} >= SCALE_CMP) ? DUTY_FULL
                                                      : product[RECIP_SHIFT +: DUTY_W];

   // Presence debounce: count samples on the far side of the threshold
   assign beyond      = present_ff ? (sample > cfg.absent_threshold)
                                   : (sample < cfg.absent_threshold);
   assign count_bump  = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;
   assign count_step  = beyond ? count_bump : '0;
   assign count_limit = present_ff ? cfg.absent_count_limit : cfg.connect_count_limit;

   // Next state for the item in hand
   always_comb begin
      armed_in   = armed_ff;
      present_in = present_ff;
      count_in   = count_ff;
      duty_in    = duty_ff;
      drive_in   = drive_ff;
      alarm      = 1'b0;
      case (kind)
         KIND_PRESENCE: begin
            if (count_step > count_limit) begin
               present_in = !present_ff;
               count_in   = '0;
            end else begin
               count_in   = count_step;
            end
         end
         KIND_CONTROL: begin
            if (!armed_ff || !present_ff) begin
               drive_in = 1'b0;
            end else begin
               duty_in = duty_calc;
               if (sample > cfg.overtemp_limit) begin
                  drive_in = 1'b0;
                  armed_in = 1'b0;
                  alarm    = 1'b1;
               end else begin
                  drive_in = 1'b1;
               end
            end
         end
         KIND_SWITCH_ON:  armed_in = 1'b1;
         KIND_SWITCH_OFF: armed_in = 1'b0;
         default:         armed_in = armed_ff;
      endcase
   end

   // Commit state once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         present_ff <= 1'b1;
         count_ff   <= '0;
         duty_ff    <= '0;
         drive_ff   <= 1'b0;
      end else if (advance) begin
         armed_ff   <= armed_in;
         present_ff <= present_in;
         count_ff   <= count_in;
         duty_ff    <= duty_in;
         drive_ff   <= drive_in;
      end
   end

   assign result.heater_enable = drive_in;
   assign result.duty          = duty_in;
   assign result.alarm         = alarm;
   assign result.present       = present_in;
   assign result.armed         = armed_in;

endmodule

// ===== rtl/heater_channel_controller_unit.sv =====
// Heater channel controller: one result per request, in order. A request is
// registered in the input register on acceptance and evaluated against the
// channel state (debounce counter, proportional duty through one constant
// reciprocal multiplier, over-temperature trip); the result lands in the
// output register. A new request is taken every cycle while the result side
// keeps up. Presence ticks debounce tool presence, control ticks update drive
// and duty, switch items arm or disarm. The user must write registers through
// the csr_ port only while the block is idle; the block does not enforce it.
module heater_channel_controller_unit #(
   parameter int unsigned FULL_SCALE = 400
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [hcc_pkg::SAMPLE_W-1:0] req_sample,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_heater_enable,
   output logic [hcc_pkg::DUTY_W-1:0]   rsp_duty,
   output logic                         rsp_alarm,
   output logic                         rsp_present,
   output logic                         rsp_armed,
   // register write port
   input  logic                         csr_write_enable,
   input  logic [hcc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [hcc_pkg::CSR_W-1:0]    csr_write_data
);
   import hcc_pkg::*;

`include "heater_channel_controller_unit_defines.svh"

   logic                in_valid_ff, in_valid_in;
   kind_type            in_kind_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   hcc_result_type      rsp_data_ff;
   hcc_result_type      result;
   hcc_cfg_type         cfg;
   logic                out_load;
   logic                req_accept;

   hcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   hcc_core #(
      .FULL_SCALE (FULL_SCALE)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .kind    (in_kind_ff),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Advance the held request whenever the output register is free or draining
   assign out_load     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !out_load;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff   <= kind_type'(req_kind);
         in_sample_ff <= req_sample;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heater_enable = rsp_data_ff.heater_enable;
   assign rsp_duty          = rsp_data_ff.duty;
   assign rsp_alarm         = rsp_data_ff.alarm;
   assign rsp_present       = rsp_data_ff.present;
   assign rsp_armed         = rsp_data_ff.armed;

   // An over-temperature trip leaves the channel disarmed with the drive off
   `HCC_ASSERT_SAME(a_alarm_disarms, clock, reset, rsp_valid_ff && rsp_alarm, !rsp_armed && !rsp_heater_enable)

   // A stalled result stays put until its transfer
   `HCC_ASSERT_NEXT(a_hold_result, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_data_ff))

   // A held request is not dropped while the result side is stalled
   `HCC_ASSERT_NEXT(a_hold_request, clock, reset, in_valid_ff && rsp_valid_ff && rsp_stall, in_valid_ff)

endmodule
